FILE: src/multilevel_queue_scheduler_macros.svh
// assertion macros for the multilevel queue scheduler
`ifndef MULTILEVEL_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

// condition that must hold at every clock edge out of reset
`define MLQ_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent on the same edge
`define MLQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent on the next edge
`define MLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define MLQ_ASSERT_HOLD(lbl, cond, msg)
`define MLQ_ASSERT_SAME(lbl, ante, cons, msg)
`define MLQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: src/mlq_pkg.sv
// types and constants shared by the multilevel queue scheduler
package mlq_pkg;

  // item codes
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // result status codes
  localparam logic [2:0] STS_ACCEPTED  = 3'd0;
  localparam logic [2:0] STS_REJECTED  = 3'd1;
  localparam logic [2:0] STS_IDLE_TICK = 3'd2;
  localparam logic [2:0] STS_RAN       = 3'd3;
  localparam logic [2:0] STS_FINISHED  = 3'd4;

  // internal class index (queue number)
  localparam logic [1:0] CLS_HIGH = 2'd0;
  localparam logic [1:0] CLS_MID  = 2'd1;
  localparam logic [1:0] CLS_LOW  = 2'd2;
  localparam int         NCLASS   = 3;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        func;
    logic [5:0]  proc_id;
    logic [15:0] burst_len;
    logic [1:0]  class_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  run_id;
    logic [31:0] time_now;
    logic        first_run;
    logic [31:0] response_time;
    logic [31:0] turnaround_time;
    logic [31:0] waiting_time;
  } out_item_t;

  // one process table entry
  typedef struct packed {
    logic [31:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [1:0]  cls;
  } proc_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QWAIT,
    S_TWAIT,
    S_FIN
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic arrive;
    logic idle_tick;
    logic pop;
    logic tbl_rd;
    logic exec;
    logic fin;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic queues_empty;
  } stat_t;

endpackage

FILE: src/mlq_ram.sv
// generic single write port ram with registered read
module mlq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/mlq_ctrl.sv
// controller state machine of the multilevel queue scheduler
module mlq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          func,
  input  mlq_pkg::stat_t stat,
  output logic          busy,
  output mlq_pkg::cmd_t cmd
);
  import mlq_pkg::*;

  state_t state_r, state_nxt;
  logic   take;

  assign take = start && (state_r == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take && func == FUNC_TICK && !stat.queues_empty) begin
          state_nxt = S_QWAIT;
        end
      end
      S_QWAIT: state_nxt = S_TWAIT;
      S_TWAIT: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy          = 1'b0;
        cmd.arrive    = take && func == FUNC_ARRIVE;
        cmd.idle_tick = take && func == FUNC_TICK && stat.queues_empty;
        cmd.pop       = take && func == FUNC_TICK && !stat.queues_empty;
      end
      S_QWAIT: cmd.tbl_rd = 1'b1;
      S_TWAIT: cmd.exec   = 1'b1;
      S_FIN:   cmd.fin    = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

FILE: src/mlq_dp.sv
// datapath of the multilevel queue scheduler: queues, process table, time
module mlq_dp #(
  parameter int MAX_PROCS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mlq_pkg::in_item_t  in_data,
  input  mlq_pkg::cmd_t      cmd,
  output mlq_pkg::stat_t     stat,
  output logic               out_valid,
  output mlq_pkg::out_item_t out_data
);
  import mlq_pkg::*;

  // ids are six bits wide, so at most 64 processes can ever be active
  localparam int PD     = (MAX_PROCS < 64) ? MAX_PROCS : 64;
  localparam int IW     = $clog2(PD);
  localparam int CW     = IW + 1;
  localparam int QAW    = IW + 2;
  localparam int QDEPTH = 2 ** QAW;
  localparam int TW     = $bits(proc_entry_t);

  // control state
  logic [31:0]   clock_r, clock_nxt;
  logic [PD-1:0] active_r, active_nxt;
  logic [PD-1:0] started_r, started_nxt;
  logic [IW-1:0] head_r [NCLASS];
  logic [IW-1:0] head_nxt [NCLASS];
  logic [IW-1:0] tail_r [NCLASS];
  logic [IW-1:0] tail_nxt [NCLASS];
  logic [CW-1:0] count_r [NCLASS];
  logic [CW-1:0] count_nxt [NCLASS];
  logic          out_valid_r, out_valid_nxt;

  // payload of the tick in flight
  logic [IW-1:0] pid_r, pid_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [31:0]   done_r, done_nxt;
  logic [31:0]   resp_r, resp_nxt;
  logic [31:0]   turn_r, turn_nxt;
  logic [15:0]   burst_r, burst_nxt;
  logic          fin_r, fin_nxt;
  logic          first_r, first_nxt;
  out_item_t     out_data_r, out_data_nxt;

  // memory ports
  logic           q_we, q_re;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [IW-1:0]  q_wdata, q_rdata;
  logic           t_we, t_re;
  logic [IW-1:0]  t_waddr, t_raddr;
  proc_entry_t    t_wdata, t_rdata;
  logic [TW-1:0]  t_rdata_raw;

  // decode helpers
  logic [1:0]    pop_cls;
  logic [1:0]    in_cls;
  logic [IW-1:0] in_idx;
  logic          id_ok;
  logic          arr_ok;
  logic [31:0]   clock_inc;
  logic [15:0]   rem_dec;
  logic          rem_done;
  logic [31:0]   wait_val;
  proc_entry_t   te_new;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    logic [IW-1:0] r;
    if (p == IW'(PD - 1)) begin
      r = '0;
    end else begin
      r = p + IW'(1);
    end
    return r;
  endfunction

  mlq_ram #(.WIDTH(IW), .DEPTH(QDEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  mlq_ram #(.WIDTH(TW), .DEPTH(PD)) u_table_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata_raw)
  );

  assign t_rdata = proc_entry_t'(t_rdata_raw);

  // highest non-empty class and empty flag
  assign stat.queues_empty = (count_r[0] == '0) && (count_r[1] == '0) && (count_r[2] == '0);
  assign pop_cls = (count_r[0] != '0) ? CLS_HIGH :
                   (count_r[1] != '0) ? CLS_MID : CLS_LOW;

  // arrival checks; class zero maps to the low queue
  assign in_cls    = (in_data.class_level == 2'd0) ? CLS_LOW : 2'(in_data.class_level - 2'd1);
  assign in_idx    = in_data.proc_id[IW-1:0];
  assign id_ok     = 32'(in_data.proc_id) < 32'(MAX_PROCS);
  assign arr_ok    = id_ok && !active_r[in_idx] && (in_data.burst_len != 16'd0);
  assign clock_inc = (clock_r == TIME_MAX) ? TIME_MAX : clock_r + 32'd1;

  // tick arithmetic
  assign rem_dec  = (t_rdata.remaining != 16'd0) ? t_rdata.remaining - 16'd1 : 16'd0;
  assign rem_done = (rem_dec == 16'd0);
  assign wait_val = (turn_r >= 32'(burst_r)) ? turn_r - 32'(burst_r) : 32'd0;

  always_comb begin
    te_new           = t_rdata;
    te_new.remaining = rem_dec;
  end

  // next state and memory commands
  always_comb begin
    clock_nxt     = clock_r;
    active_nxt    = active_r;
    started_nxt   = started_r;
    for (int c = 0; c < NCLASS; c++) begin
      head_nxt[c]  = head_r[c];
      tail_nxt[c]  = tail_r[c];
      count_nxt[c] = count_r[c];
    end
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    pid_nxt       = pid_r;
    now_nxt       = now_r;
    done_nxt      = done_r;
    resp_nxt      = resp_r;
    turn_nxt      = turn_r;
    burst_nxt     = burst_r;
    fin_nxt       = fin_r;
    first_nxt     = first_r;
    q_we          = 1'b0;
    q_waddr       = '0;
    q_wdata       = '0;
    q_re          = 1'b0;
    q_raddr       = '0;
    t_we          = 1'b0;
    t_waddr       = '0;
    t_wdata       = '0;
    t_re          = 1'b0;
    t_raddr       = '0;

    // arrival: admit or reject, result in the next cycle
    if (cmd.arrive) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt                 = '0;
      out_data_nxt.run_id          = in_data.proc_id;
      out_data_nxt.time_now        = clock_r;
      if (arr_ok) begin
        out_data_nxt.status        = STS_ACCEPTED;
        active_nxt[in_idx]         = 1'b1;
        started_nxt[in_idx]        = 1'b0;
        t_we                       = 1'b1;
        t_waddr                    = in_idx;
        t_wdata.arrival            = clock_r;
        t_wdata.burst              = in_data.burst_len;
        t_wdata.remaining          = in_data.burst_len;
        t_wdata.cls                = in_cls;
        q_we                       = 1'b1;
        q_waddr                    = {in_cls, tail_r[in_cls]};
        q_wdata                    = in_idx;
        tail_nxt[in_cls]           = ptr_inc(tail_r[in_cls]);
        count_nxt[in_cls]          = count_r[in_cls] + CW'(1);
      end else begin
        out_data_nxt.status        = STS_REJECTED;
      end
    end

    // tick with all queues empty
    if (cmd.idle_tick) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt          = '0;
      out_data_nxt.status   = STS_IDLE_TICK;
      out_data_nxt.time_now = clock_r;
      clock_nxt             = clock_inc;
    end

    // tick: pop the head of the chosen class and advance time
    if (cmd.pop) begin
      q_re               = 1'b1;
      q_raddr            = {pop_cls, head_r[pop_cls]};
      head_nxt[pop_cls]  = ptr_inc(head_r[pop_cls]);
      count_nxt[pop_cls] = count_r[pop_cls] - CW'(1);
      now_nxt            = clock_r;
      done_nxt           = clock_inc;
      clock_nxt          = clock_inc;
    end

    // look up the popped process
    if (cmd.tbl_rd) begin
      pid_nxt = q_rdata;
      t_re    = 1'b1;
      t_raddr = q_rdata;
    end

    // run one unit, write back, requeue unless finished
    if (cmd.exec) begin
      t_we                = 1'b1;
      t_waddr             = pid_r;
      t_wdata             = te_new;
      first_nxt           = !started_r[pid_r];
      started_nxt[pid_r]  = 1'b1;
      fin_nxt             = rem_done;
      resp_nxt            = now_r - t_rdata.arrival;
      turn_nxt            = done_r - t_rdata.arrival;
      burst_nxt           = t_rdata.burst;
      if (rem_done) begin
        active_nxt[pid_r] = 1'b0;
      end else begin
        q_we                    = 1'b1;
        q_waddr                 = {t_rdata.cls, tail_r[t_rdata.cls]};
        q_wdata                 = pid_r;
        tail_nxt[t_rdata.cls]   = ptr_inc(tail_r[t_rdata.cls]);
        count_nxt[t_rdata.cls]  = count_r[t_rdata.cls] + CW'(1);
      end
    end

    // waiting time and result of the tick
    if (cmd.fin) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.status          = fin_r ? STS_FINISHED : STS_RAN;
      out_data_nxt.run_id          = 6'(pid_r);
      out_data_nxt.time_now        = now_r;
      out_data_nxt.first_run       = first_r;
      out_data_nxt.response_time   = first_r ? resp_r : 32'd0;
      out_data_nxt.turnaround_time = fin_r ? turn_r : 32'd0;
      out_data_nxt.waiting_time    = fin_r ? wait_val : 32'd0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r     <= '0;
      active_r    <= '0;
      started_r   <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NCLASS; c++) begin
        head_r[c]  <= '0;
        tail_r[c]  <= '0;
        count_r[c] <= '0;
      end
    end else begin
      clock_r     <= clock_nxt;
      active_r    <= active_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      for (int c = 0; c < NCLASS; c++) begin
        head_r[c]  <= head_nxt[c];
        tail_r[c]  <= tail_nxt[c];
        count_r[c] <= count_nxt[c];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pid_r      <= pid_nxt;
    now_r      <= now_nxt;
    done_r     <= done_nxt;
    resp_r     <= resp_nxt;
    turn_r     <= turn_nxt;
    burst_r    <= burst_nxt;
    fin_r      <= fin_nxt;
    first_r    <= first_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/multilevel_queue_scheduler.sv
// top level of the multilevel queue scheduler
// An item transfers at a rising edge with start high and busy low. An arrival
// leaves busy low and its result is on out_data, with out_valid high, in the
// cycle after the transfer, so arrivals can be given in every cycle. A tick
// that finds a process to run goes in order through the class queue ram read,
// the process table ram read, the update and write back, and the waiting time
// subtract, with busy high until its result appears. A tick with all queues
// empty is answered like an arrival, in the cycle after its transfer. Each
// result is shown for exactly one cycle and must be taken then; the receiver
// cannot stall the block.
`include "multilevel_queue_scheduler_macros.svh"

module multilevel_queue_scheduler #(
  parameter int MAX_PROCS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mlq_pkg::in_item_t  in_data,
  output logic               out_valid,
  output mlq_pkg::out_item_t out_data
);
  import mlq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mlq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  mlq_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // an arrival always answers in the next cycle
  `MLQ_ASSERT_NEXT(a_arrive_result, start && !busy && in_data.func == FUNC_ARRIVE, out_valid, "arrival without result")

  // a result is only shown once the block is free again
  `MLQ_ASSERT_SAME(a_result_idle, out_valid, !busy, "result while busy")

  // waiting time never exceeds turnaround on a finish
  `MLQ_ASSERT_SAME(a_wait_le_turn, out_valid && out_data.status == STS_FINISHED, out_data.waiting_time <= out_data.turnaround_time, "waiting above turnaround")

  // an idle tick reports no process
  `MLQ_ASSERT_SAME(a_idle_no_id, out_valid && out_data.status == STS_IDLE_TICK, out_data.run_id == 6'd0 && !out_data.first_run, "idle tick with process")

endmodule

FILE: tb/tb.sv
// self-checking testbench for the multilevel queue scheduler
module tb;
  import mlq_pkg::*;

  // class_level codes as seen on the input item
  localparam logic [1:0] LEVEL_ZERO = 2'd0;
  localparam logic [1:0] LEVEL_HIGH = 2'd1;
  localparam logic [1:0] LEVEL_MID  = 2'd2;
  localparam logic [1:0] LEVEL_LOW  = 2'd3;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 660;

  // one pending item with its sender gap rate and drain request
  typedef struct packed {
    in_item_t   item;
    logic [6:0] gap_pct;
    logic       drain;
  } feed_entry_t;

  logic      clk;
  logic      rst_n;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  multilevel_queue_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // scheduler shadow state
  logic [31:0] sim_clock = '0;
  bit          live       [64];
  bit          ran_before [64];
  logic [31:0] arr_time   [64];
  logic [15:0] need       [64];
  logic [15:0] left       [64];
  logic [1:0]  home       [64];
  logic [5:0]  ready_hi  [$];
  logic [5:0]  ready_mid [$];
  logic [5:0]  ready_lo  [$];

  out_item_t   due_results [$];
  feed_entry_t job_feed    [$];
  feed_entry_t cur = '0;
  bit          holding = 1'b0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  bit          timed_out = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void ready_push(input logic [1:0] q, input logic [5:0] id);
    case (q)
      CLS_HIGH: ready_hi  = {ready_hi, id};
      CLS_MID:  ready_mid = {ready_mid, id};
      default:  ready_lo  = {ready_lo, id};
    endcase
  endfunction

  // compute the result of one transferred item and update the shadow state
  task automatic sched_predict(input in_item_t it);
    out_item_t   r;
    logic [1:0]  q;
    logic [5:0]  p;
    logic [31:0] done_at;
    logic [31:0] turn;
    bit          found;
    r = '0;
    r.time_now = sim_clock;
    if (it.func == FUNC_ARRIVE) begin
      r.run_id = it.proc_id;
      if (live[it.proc_id] || it.burst_len == 16'd0) begin
        r.status = STS_REJECTED;
      end else begin
        q = (it.class_level == LEVEL_ZERO) ? CLS_LOW : it.class_level - 2'd1;
        live[it.proc_id]       = 1'b1;
        ran_before[it.proc_id] = 1'b0;
        arr_time[it.proc_id]   = sim_clock;
        need[it.proc_id]       = it.burst_len;
        left[it.proc_id]       = it.burst_len;
        home[it.proc_id]       = q;
        ready_push(q, it.proc_id);
        r.status = STS_ACCEPTED;
      end
    end else begin
      // highest non-empty class wins
      found = 1'b1;
      p = '0;
      if (ready_hi.size() != 0) p = ready_hi.pop_front();
      else if (ready_mid.size() != 0) p = ready_mid.pop_front();
      else if (ready_lo.size() != 0) p = ready_lo.pop_front();
      else found = 1'b0;
      if (!found) begin
        r.status = STS_IDLE_TICK;
      end else begin
        r.run_id = p;
        if (!ran_before[p]) begin
          ran_before[p]   = 1'b1;
          r.first_run     = 1'b1;
          r.response_time = sim_clock - arr_time[p];
        end
        if (left[p] != 16'd0) left[p] = left[p] - 16'd1;
        if (left[p] == 16'd0) begin
          done_at = (sim_clock == TIME_MAX) ? TIME_MAX : sim_clock + 32'd1;
          turn    = done_at - arr_time[p];
          r.turnaround_time = turn;
          r.waiting_time    = (turn >= {16'd0, need[p]}) ? turn - {16'd0, need[p]} : 32'd0;
          live[p]  = 1'b0;
          r.status = STS_FINISHED;
        end else begin
          ready_push(home[p], p);
          r.status = STS_RAN;
        end
      end
      if (sim_clock != TIME_MAX) sim_clock = sim_clock + 32'd1;
    end
    due_results = {due_results, r};
  endtask

  function automatic in_item_t arrive(input logic [5:0] id, input logic [15:0] b,
                                      input logic [1:0] lvl);
    in_item_t it;
    it.func        = FUNC_ARRIVE;
    it.proc_id     = id;
    it.burst_len   = b;
    it.class_level = lvl;
    return it;
  endfunction

  // tick with random don't-care fields
  function automatic in_item_t tick();
    in_item_t it;
    it.func        = FUNC_TICK;
    it.proc_id     = 6'($urandom);
    it.burst_len   = 16'($urandom);
    it.class_level = 2'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] pick_burst();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return 16'd0;
    else if (roll < 6) return 16'($urandom_range(400, 100));
    else if (roll < 20) return 16'($urandom_range(60, 5));
    else return 16'($urandom_range(4, 1));
  endfunction

  task automatic queue_job(input in_item_t it, input int unsigned pct, input bit drain);
    feed_entry_t e;
    e.item    = it;
    e.gap_pct = 7'(pct);
    e.drain   = drain;
    job_feed  = {job_feed, e};
  endtask

  // arrivals in single shots and floods, ticks in short runs
  task automatic fill_random(input int unsigned n, input int unsigned pct);
    int unsigned added;
    int unsigned roll;
    int unsigned len;
    int unsigned k;
    added = 0;
    while (added < n) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        len = $urandom_range(40, 8);
        for (k = 0; k < len; k++) begin
          queue_job(arrive(6'($urandom), 16'($urandom_range(3, 1)), 2'($urandom)),
                    pct, added == 0);
          added++;
        end
      end else if (roll < 35) begin
        queue_job(arrive(6'($urandom), pick_burst(), 2'($urandom)), pct, added == 0);
        added++;
      end else begin
        len = $urandom_range(6, 1);
        for (k = 0; k < len; k++) begin
          queue_job(tick(), pct, added == 0);
          added++;
        end
      end
    end
  endtask

  // driver: present items from the feed, predict on each transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sched_predict(in_data);
        holding = 1'b0;
      end
      if (!holding && job_feed.size() != 0) begin
        if (!job_feed[0].drain ||
            (due_results.size() == 0 && !out_valid && !busy)) begin
          if ($urandom_range(99) >= job_feed[0].gap_pct) begin
            cur     = job_feed.pop_front();
            holding = 1'b1;
          end
        end
      end
      start   <= holding;
      in_data <= cur.item;
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        log_error($sformatf("result %h with nothing expected", out_data));
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status)
          log_error($sformatf("status: expected %0d got %0d", want.status, out_data.status));
        if (out_data.run_id !== want.run_id)
          log_error($sformatf("run_id: expected %0d got %0d", want.run_id, out_data.run_id));
        if (out_data.time_now !== want.time_now)
          log_error($sformatf("time_now: expected %0d got %0d",
                              want.time_now, out_data.time_now));
        if (out_data.first_run !== want.first_run)
          log_error($sformatf("first_run: expected %0d got %0d",
                              want.first_run, out_data.first_run));
        if (out_data.response_time !== want.response_time)
          log_error($sformatf("response_time: expected %0d got %0d",
                              want.response_time, out_data.response_time));
        if (out_data.turnaround_time !== want.turnaround_time)
          log_error($sformatf("turnaround_time: expected %0d got %0d",
                              want.turnaround_time, out_data.turnaround_time));
        if (out_data.waiting_time !== want.waiting_time)
          log_error($sformatf("waiting_time: expected %0d got %0d",
                              want.waiting_time, out_data.waiting_time));
      end
    end
  end

  // watchdog: cycles with no transfer in either direction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int unsigned i;
    rst_n = 1'b0;

    // directed: idle tick, rejections, class zero, priority and round robin
    queue_job(tick(), 32, 1'b0);
    queue_job(arrive(6'd0, 16'd1, LEVEL_HIGH), 32, 1'b0);
    queue_job(arrive(6'd63, 16'd3, LEVEL_LOW), 32, 1'b0);
    queue_job(arrive(6'd0, 16'hFFFF, LEVEL_MID), 32, 1'b0);
    queue_job(arrive(6'd10, 16'd0, LEVEL_HIGH), 32, 1'b0);
    queue_job(arrive(6'd20, 16'd2, LEVEL_ZERO), 32, 1'b0);
    queue_job(arrive(6'd21, 16'd2, LEVEL_MID), 32, 1'b0);
    queue_job(arrive(6'd63, 16'hAAAA, LEVEL_ZERO), 32, 1'b0);
    queue_job(arrive(6'd21, 16'h5555, LEVEL_HIGH), 32, 1'b0);
    for (i = 0; i < 10; i++) queue_job(tick(), 32, 1'b0);
    queue_job(arrive(6'd0, 16'd2, LEVEL_HIGH), 32, 1'b0);
    queue_job(arrive(6'd42, 16'd1, LEVEL_LOW), 32, 1'b0);
    for (i = 0; i < 4; i++) queue_job(tick(), 32, 1'b0);

    // random phases: sender gaps 32, then 76, then none; each starts drained
    fill_random(PHASE_ITEMS, 32);
    fill_random(PHASE_ITEMS, 76);
    fill_random(PHASE_ITEMS, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    fork
      begin
        while (job_feed.size() != 0 || holding || due_results.size() != 0)
          @(posedge clk);
        repeat (8) @(posedge clk);
      end
      begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && errors == 0 && due_results.size() == 0) begin
      $display("** multilevel_queue_scheduler: PASSED **");
    end else begin
      $display("** multilevel_queue_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
